@@ rtl/core/mprf_pkg.sv @@
package mprf_pkg;

   // Defaults for the top-level parameters
   localparam int NUM_PORTS_DEF      = 4;
   localparam int MAX_DEPTH_LOG2_DEF = 8;
   localparam int MAX_BURST_DEF      = 32;

   // Fixed field widths
   localparam int ACTION_W  = 2;
   localparam int PORT_W    = 2;
   localparam int DATA_W    = 16;
   localparam int COUNT_W   = 6;
   localparam int SIZE_W    = 4;
   localparam int REG_IDX_W = 2;
   localparam int NUM_REGS  = 4;

   localparam logic [SIZE_W-1:0] SIZE_RESET = 4'd8;

   typedef enum logic [ACTION_W-1:0] {
      ACT_WRITE = 2'd0,
      ACT_READ  = 2'd1,
      ACT_FLUSH = 2'd2,
      ACT_NOP   = 2'd3
   } action_type;

   typedef enum logic {
      ST_IDLE = 1'b0,
      ST_READ = 1'b1
   } state_type;

   typedef struct packed {
      logic               strobe;
      logic [PORT_W-1:0]  port_out;
      logic               rdata_valid;
      logic               write_taken;
      logic [COUNT_W-1:0] granted;
      logic               is_empty;
      logic               last;
   } rsp_type;

endpackage

@@ rtl/core/multi_port_ring_fifo.sv @@
// Channel   | Ports                                   | Beat taken when
// ----------+-----------------------------------------+----------------------------
// request   | start, busy, req_action .. req_req_count | start & !busy at clock edge
// response  | rsp_strobe, rsp_port_out .. rsp_last     | every cycle rsp_strobe is high
// csr write | csr_valid, csr_ready, csr_index, csr_data| csr_valid & csr_ready
//
// Write, flush, no-op and reads that grant no words: the response beat shows up the
// cycle after acceptance and busy stays low.
// A read granting n words keeps busy high while the word store streams one word
// per cycle through its single read port; each beat follows its read in the next cycle.
// Reset (synchronous) clears all counters and sets every size register to 8; no
// clearing pass, the word store is left as is.
// The response side cannot stall; csr writes are expected only while idle.
module multi_port_ring_fifo #(
   parameter int NUM_PORTS      = mprf_pkg::NUM_PORTS_DEF,
   parameter int MAX_DEPTH_LOG2 = mprf_pkg::MAX_DEPTH_LOG2_DEF,
   parameter int MAX_BURST      = mprf_pkg::MAX_BURST_DEF
) (
   input  logic                            clock,
   input  logic                            reset,

   input  logic                            start,
   output logic                            busy,
   input  logic [mprf_pkg::ACTION_W-1:0]   req_action,
   input  logic [mprf_pkg::PORT_W-1:0]     req_port_sel,
   input  logic [mprf_pkg::DATA_W-1:0]     req_wdata,
   input  logic [mprf_pkg::COUNT_W-1:0]    req_req_count,

   output logic                            rsp_strobe,
   output logic [mprf_pkg::PORT_W-1:0]     rsp_port_out,
   output logic [mprf_pkg::DATA_W-1:0]     rsp_rdata,
   output logic                            rsp_rdata_valid,
   output logic                            rsp_write_taken,
   output logic [mprf_pkg::COUNT_W-1:0]    rsp_granted,
   output logic                            rsp_is_empty,
   output logic                            rsp_last,

   input  logic                            csr_valid,
   output logic                            csr_ready,
   input  logic [mprf_pkg::REG_IDX_W-1:0]  csr_index,
   input  logic [mprf_pkg::SIZE_W-1:0]     csr_data
);

   localparam int CW      = MAX_DEPTH_LOG2 + 1;              // free-running counter width
   localparam int DEPTH   = NUM_PORTS << MAX_DEPTH_LOG2;     // one region per port
   localparam int AW      = $clog2(DEPTH);
   localparam int PIW     = (NUM_PORTS > 1) ? $clog2(NUM_PORTS) : 1;
   localparam int GW      = mprf_pkg::COUNT_W;
   localparam int SW      = mprf_pkg::SIZE_W;

   // ---------------------------------------------------------------------------
   // State
   // ---------------------------------------------------------------------------
   mprf_pkg::state_type   state_ff, state_in;
   logic [CW-1:0]         wc_ff [NUM_PORTS];
   logic [CW-1:0]         wc_in [NUM_PORTS];
   logic [CW-1:0]         rc_ff [NUM_PORTS];
   logic [CW-1:0]         rc_in [NUM_PORTS];
   logic [SW-1:0]         size_ff [mprf_pkg::NUM_REGS];
   logic [SW-1:0]         size_in [mprf_pkg::NUM_REGS];

   // read burst context
   logic [mprf_pkg::PORT_W-1:0] port_ff, port_in;
   logic [CW-1:0]               ptr_ff, ptr_in;
   logic [MAX_DEPTH_LOG2-1:0]   mask_ff, mask_in;
   logic [GW-1:0]               left_ff, left_in;
   logic [GW-1:0]               grant_ff, grant_in;
   logic                        empty_ff, empty_in;

   mprf_pkg::rsp_type           rsp_ff, rsp_in;

   // ---------------------------------------------------------------------------
   // Decode of the offered request
   // ---------------------------------------------------------------------------
   logic                      accept;
   logic                      in_range;
   logic [PIW-1:0]            pidx;
   logic [CW-1:0]             wc_cur, rc_cur, fill, cap, wc_plus, rc_after;
   logic [SW-1:0]             size_raw, size_eff;
   logic [MAX_DEPTH_LOG2-1:0] mask_cur;
   logic                      has_room;
   logic [GW-1:0]             burst_lim, n_cur;
   logic                      is_write, is_read, is_flush;

   assign accept   = start && !busy;
   assign in_range = 32'(req_port_sel) < NUM_PORTS;
   assign pidx     = PIW'(req_port_sel);
   assign is_write = req_action == mprf_pkg::ACT_WRITE;
   assign is_read  = req_action == mprf_pkg::ACT_READ;
   assign is_flush = req_action == mprf_pkg::ACT_FLUSH;

   always_comb begin
      wc_cur   = in_range ? wc_ff[pidx] : '0;
      rc_cur   = in_range ? rc_ff[pidx] : '0;
      size_raw = size_ff[req_port_sel];
      // sizes above the supported maximum act as the maximum
      if (32'(size_raw) > MAX_DEPTH_LOG2) begin
         size_eff = SW'(MAX_DEPTH_LOG2);
      end else begin
         size_eff = size_raw;
      end
      cap      = CW'(1) << size_eff;
      mask_cur = MAX_DEPTH_LOG2'(cap - CW'(1));
      fill     = wc_cur - rc_cur;
      has_room = fill < cap;
      wc_plus  = wc_cur + CW'(1);
      if (32'(req_req_count) > MAX_BURST) begin
         burst_lim = GW'(MAX_BURST);
      end else begin
         burst_lim = req_req_count;
      end
      if (32'(fill) < 32'(burst_lim)) begin
         n_cur = GW'(fill);
      end else begin
         n_cur = burst_lim;
      end
      rc_after = rc_cur + CW'(n_cur);
   end

   // ---------------------------------------------------------------------------
   // Next state
   // ---------------------------------------------------------------------------
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         mprf_pkg::ST_IDLE: begin
            if (accept && in_range && is_read && (n_cur != '0)) begin
               state_in = mprf_pkg::ST_READ;
            end
         end
         mprf_pkg::ST_READ: begin
            if (left_ff == GW'(1)) begin
               state_in = mprf_pkg::ST_IDLE;
            end
         end
         default: state_in = mprf_pkg::ST_IDLE;
      endcase
   end

   // counters, size registers, burst context
   always_comb begin
      wc_in    = wc_ff;
      rc_in    = rc_ff;
      size_in  = size_ff;
      port_in  = port_ff;
      ptr_in   = ptr_ff;
      mask_in  = mask_ff;
      left_in  = left_ff;
      grant_in = grant_ff;
      empty_in = empty_ff;

      if (state_ff == mprf_pkg::ST_READ) begin
         ptr_in  = ptr_ff + CW'(1);
         left_in = left_ff - GW'(1);
      end else if (accept && in_range) begin
         if (is_write && has_room) begin
            wc_in[pidx] = wc_plus;
         end
         if (is_read) begin
            rc_in[pidx] = rc_after;
            port_in     = req_port_sel;
            ptr_in      = rc_cur;
            mask_in     = mask_cur;
            left_in     = n_cur;
            grant_in    = n_cur;
            empty_in    = wc_cur == rc_after;
         end
         if (is_flush) begin
            wc_in[pidx] = '0;
            rc_in[pidx] = '0;
         end
      end

      // a size write restarts its port
      if (csr_valid && csr_ready) begin
         size_in[csr_index] = csr_data;
         if (32'(csr_index) < NUM_PORTS) begin
            wc_in[PIW'(csr_index)] = '0;
            rc_in[PIW'(csr_index)] = '0;
         end
      end
   end

   // response beat
   always_comb begin
      rsp_in = '0;
      if (state_ff == mprf_pkg::ST_READ) begin
         rsp_in.strobe      = 1'b1;
         rsp_in.port_out    = port_ff;
         rsp_in.rdata_valid = 1'b1;
         rsp_in.granted     = grant_ff;
         rsp_in.is_empty    = empty_ff;
         rsp_in.last        = left_ff == GW'(1);
      end else if (accept) begin
         rsp_in.strobe   = 1'b1;
         rsp_in.port_out = req_port_sel;
         rsp_in.last     = 1'b1;
         if (!in_range) begin
            rsp_in.is_empty = 1'b1;
         end else begin
            case (mprf_pkg::action_type'(req_action))
               mprf_pkg::ACT_WRITE: begin
                  rsp_in.write_taken = has_room;
                  rsp_in.is_empty    = (has_room ? wc_plus : wc_cur) == rc_cur;
               end
               mprf_pkg::ACT_READ: begin
                  // a granted read reports from the streaming beats instead
                  rsp_in.strobe   = n_cur == '0;
                  rsp_in.is_empty = wc_cur == rc_cur;
               end
               mprf_pkg::ACT_FLUSH: begin
                  rsp_in.is_empty = 1'b1;
               end
               mprf_pkg::ACT_NOP: begin
                  rsp_in.is_empty = wc_cur == rc_cur;
               end
               default: rsp_in.is_empty = wc_cur == rc_cur;
            endcase
         end
      end
   end

   // ---------------------------------------------------------------------------
   // Registers
   // ---------------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= mprf_pkg::ST_IDLE;
         for (int i = 0; i < NUM_PORTS; i++) begin
            wc_ff[i] <= '0;
            rc_ff[i] <= '0;
         end
         for (int i = 0; i < mprf_pkg::NUM_REGS; i++) begin
            size_ff[i] <= mprf_pkg::SIZE_RESET;
         end
         left_ff <= '0;
         rsp_ff  <= '0;
      end else begin
         state_ff <= state_in;
         wc_ff    <= wc_in;
         rc_ff    <= rc_in;
         size_ff  <= size_in;
         left_ff  <= left_in;
         rsp_ff   <= rsp_in;
      end
   end

   always_ff @(posedge clock) begin
      port_ff  <= port_in;
      ptr_ff   <= ptr_in;
      mask_ff  <= mask_in;
      grant_ff <= grant_in;
      empty_ff <= empty_in;
   end

   // ---------------------------------------------------------------------------
   // Word store: writes on accept, burst reads one word per cycle
   // ---------------------------------------------------------------------------
   logic                          ram_we, ram_re;
   logic [AW-1:0]                 ram_waddr, ram_raddr;
   logic [mprf_pkg::DATA_W-1:0]   ram_q;

   assign ram_we    = accept && in_range && is_write && has_room;
   assign ram_waddr = AW'({req_port_sel, wc_cur[MAX_DEPTH_LOG2-1:0] & mask_cur});
   assign ram_re    = state_ff == mprf_pkg::ST_READ;
   assign ram_raddr = AW'({port_ff, ptr_ff[MAX_DEPTH_LOG2-1:0] & mask_ff});

   mprf_ram #(
      .WIDTH (mprf_pkg::DATA_W),
      .DEPTH (DEPTH)
   ) u_store (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (req_wdata),
      .rd_en   (ram_re),
      .rd_addr (ram_raddr),
      .rd_data (ram_q)
   );

   // ---------------------------------------------------------------------------
   // Outputs
   // ---------------------------------------------------------------------------
   always_comb begin
      busy = state_ff == mprf_pkg::ST_READ;
   end

   assign csr_ready       = 1'b1;
   assign rsp_strobe      = rsp_ff.strobe;
   assign rsp_port_out    = rsp_ff.port_out;
   assign rsp_rdata       = rsp_ff.rdata_valid ? ram_q : '0;
   assign rsp_rdata_valid = rsp_ff.rdata_valid;
   assign rsp_write_taken = rsp_ff.write_taken;
   assign rsp_granted     = rsp_ff.granted;
   assign rsp_is_empty    = rsp_ff.is_empty;
   assign rsp_last        = rsp_ff.last;

   // ---------------------------------------------------------------------------
   // Assertions
   // ---------------------------------------------------------------------------
   a_burst_nonzero: assert property (@(posedge clock) disable iff (reset)
      (state_ff == mprf_pkg::ST_READ) |-> (left_ff != '0))
      else $error("read burst running with no words left");

   a_burst_ends: assert property (@(posedge clock) disable iff (reset)
      (state_ff == mprf_pkg::ST_READ && left_ff == GW'(1)) |=> !busy)
      else $error("busy held after final burst word");

   a_single_beat: assert property (@(posedge clock) disable iff (reset)
      (accept && req_action != mprf_pkg::ACT_READ) |=> (rsp_strobe && rsp_last))
      else $error("non-read request produced no final beat");

   a_word_granted: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && rsp_rdata_valid) |-> (rsp_granted != '0 && !rsp_write_taken))
      else $error("data beat without a grant");

endmodule

@@ rtl/core/mprf_ram.sv @@
module mprf_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

@@ verif/testbench.sv @@
`timescale 1ns / 1ps

// Self-checking bench for multi_port_ring_fifo.
// Request beats go in on start/busy. Every accepted op is run through a local
// model of the four ring FIFOs, which queues the response beats it owes. Response
// beats cannot be stalled, so each strobe is checked against the oldest queued beat.
module testbench;

   localparam int N_PORTS      = mprf_pkg::NUM_PORTS_DEF;
   localparam int DEPTH_LOG2   = mprf_pkg::MAX_DEPTH_LOG2_DEF;
   localparam int BURST_MAX    = mprf_pkg::MAX_BURST_DEF;
   localparam int CNT_W        = DEPTH_LOG2 + 1;
   localparam int CNT_MASK     = (1 << CNT_W) - 1;
   localparam int SLOT_WORDS   = 1 << DEPTH_LOG2;
   localparam int REG_SIZE_BASE = 0;   // size register of port p sits at base + p
   localparam int N_PHASES     = 6;
   localparam int PHASE_ITEMS  = 72;
   localparam int CSR_SETTLE   = 4;
   localparam int END_SETTLE   = 40;
   localparam int CYCLE_LIMIT  = 300000;
   localparam int REPORT_MAX   = 10;

   // one response beat, field for field
   typedef struct packed {
      logic [mprf_pkg::PORT_W-1:0]  port_id;
      logic [mprf_pkg::DATA_W-1:0]  word;
      logic                         word_valid;
      logic                         stored;
      logic [mprf_pkg::COUNT_W-1:0] grant;
      logic                         empty;
      logic                         tail;
   } fifo_beat_type;

   // directed op; typed rows carry their single beat's write_taken / is_empty
   typedef struct packed {
      mprf_pkg::action_type         act;
      logic [mprf_pkg::PORT_W-1:0]  port_id;
      logic [mprf_pkg::DATA_W-1:0]  data;
      logic [mprf_pkg::COUNT_W-1:0] want;
      logic                         typed;
      logic                         taken;
      logic                         empty;
   } stim_row_type;

   // Run after port 1 is set to one word and port 2 to an oversized code;
   // ports 0 and 3 keep their reset size.
   stim_row_type directed_rows [22] = '{
      // read of empty port after reset
      '{mprf_pkg::ACT_READ,  2'd0, 16'h0000, 6'd5,  1'b1, 1'b0, 1'b1},
      '{mprf_pkg::ACT_NOP,   2'd1, 16'hFFFF, 6'd63, 1'b1, 1'b0, 1'b1},
      '{mprf_pkg::ACT_FLUSH, 2'd2, 16'h0000, 6'd0,  1'b1, 1'b0, 1'b1},
      '{mprf_pkg::ACT_WRITE, 2'd0, 16'h0000, 6'd0,  1'b1, 1'b1, 1'b0},
      '{mprf_pkg::ACT_WRITE, 2'd0, 16'hFFFF, 6'd63, 1'b1, 1'b1, 1'b0},
      '{mprf_pkg::ACT_WRITE, 2'd0, 16'hA5A5, 6'd1,  1'b0, 1'b0, 1'b0},
      '{mprf_pkg::ACT_WRITE, 2'd0, 16'h5A5A, 6'd2,  1'b0, 1'b0, 1'b0},
      // zero request grants nothing
      '{mprf_pkg::ACT_READ,  2'd0, 16'h0000, 6'd0,  1'b1, 1'b0, 1'b0},
      '{mprf_pkg::ACT_READ,  2'd0, 16'hFFFF, 6'd3,  1'b0, 1'b0, 1'b0},
      // oversized request
      '{mprf_pkg::ACT_READ,  2'd0, 16'h0000, 6'd63, 1'b0, 1'b0, 1'b0},
      '{mprf_pkg::ACT_READ,  2'd0, 16'h0000, 6'd1,  1'b1, 1'b0, 1'b1},
      '{mprf_pkg::ACT_WRITE, 2'd1, 16'h8001, 6'd0,  1'b1, 1'b1, 1'b0},
      // full: word dropped
      '{mprf_pkg::ACT_WRITE, 2'd1, 16'h7FFE, 6'd0,  1'b1, 1'b0, 1'b0},
      '{mprf_pkg::ACT_NOP,   2'd1, 16'h0000, 6'd0,  1'b1, 1'b0, 1'b0},
      '{mprf_pkg::ACT_READ,  2'd1, 16'h0000, 6'd32, 1'b0, 1'b0, 1'b0},
      // wraps the one-word ring
      '{mprf_pkg::ACT_WRITE, 2'd1, 16'h1234, 6'd0,  1'b1, 1'b1, 1'b0},
      '{mprf_pkg::ACT_FLUSH, 2'd1, 16'h0000, 6'd0,  1'b1, 1'b0, 1'b1},
      '{mprf_pkg::ACT_WRITE, 2'd2, 16'hC3C3, 6'd0,  1'b1, 1'b1, 1'b0},
      '{mprf_pkg::ACT_WRITE, 2'd3, 16'h3C3C, 6'd0,  1'b1, 1'b1, 1'b0},
      '{mprf_pkg::ACT_READ,  2'd2, 16'h0000, 6'd32, 1'b0, 1'b0, 1'b0},
      '{mprf_pkg::ACT_FLUSH, 2'd3, 16'hFFFF, 6'd63, 1'b1, 1'b0, 1'b1},
      '{mprf_pkg::ACT_NOP,   2'd3, 16'h0000, 6'd0,  1'b1, 1'b0, 1'b1}
   };

   // size codes of the first random phases: extremes, oversized, smallest rings
   localparam logic [mprf_pkg::SIZE_W-1:0] PHASE_SIZES [3][4] = '{
      '{4'd0, 4'd1, 4'd2, 4'd3},
      '{4'd8, 4'd15, 4'd5, 4'd4},
      '{4'd3, 4'd0, 4'd8, 4'd1}
   };

   logic                           clock;
   logic                           reset = 1'b1;
   logic                           start = 1'b0;
   logic                           busy;
   logic [mprf_pkg::ACTION_W-1:0]  req_action = mprf_pkg::ACT_NOP;
   logic [mprf_pkg::PORT_W-1:0]    req_port_sel = '0;
   logic [mprf_pkg::DATA_W-1:0]    req_wdata = '0;
   logic [mprf_pkg::COUNT_W-1:0]   req_req_count = '0;
   logic                           rsp_strobe;
   logic [mprf_pkg::PORT_W-1:0]    rsp_port_out;
   logic [mprf_pkg::DATA_W-1:0]    rsp_rdata;
   logic                           rsp_rdata_valid;
   logic                           rsp_write_taken;
   logic [mprf_pkg::COUNT_W-1:0]   rsp_granted;
   logic                           rsp_is_empty;
   logic                           rsp_last;
   logic                           csr_valid = 1'b0;
   logic                           csr_ready;
   logic [mprf_pkg::REG_IDX_W-1:0] csr_index = '0;
   logic [mprf_pkg::SIZE_W-1:0]    csr_data = '0;

   // local copy of the ring state
   logic [mprf_pkg::DATA_W-1:0] word_mem [N_PORTS][SLOT_WORDS];
   logic [CNT_W-1:0]            wr_cnt [N_PORTS];
   logic [CNT_W-1:0]            rd_cnt [N_PORTS];
   logic [mprf_pkg::SIZE_W-1:0] size_cfg [N_PORTS];

   fifo_beat_type rsp_beats_due [$];
   int            error_count = 0;
   int            cycle_count = 0;
   bit            idle_gaps = 1'b1;

   multi_port_ring_fifo #(
      .NUM_PORTS      (N_PORTS),
      .MAX_DEPTH_LOG2 (DEPTH_LOG2),
      .MAX_BURST      (BURST_MAX)
   ) uut (
      .clock           (clock),
      .reset           (reset),
      .start           (start),
      .busy            (busy),
      .req_action      (req_action),
      .req_port_sel    (req_port_sel),
      .req_wdata       (req_wdata),
      .req_req_count   (req_req_count),
      .rsp_strobe      (rsp_strobe),
      .rsp_port_out    (rsp_port_out),
      .rsp_rdata       (rsp_rdata),
      .rsp_rdata_valid (rsp_rdata_valid),
      .rsp_write_taken (rsp_write_taken),
      .rsp_granted     (rsp_granted),
      .rsp_is_empty    (rsp_is_empty),
      .rsp_last        (rsp_last),
      .csr_valid       (csr_valid),
      .csr_ready       (csr_ready),
      .csr_index       (csr_index),
      .csr_data        (csr_data)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   // hard stop if the bench hangs on a handshake
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("simulation failed");
         $finish;
      end
   end

   // Works out the response beats of one accepted op and advances the ring state.
   // Ports are never out of range here: the select is as wide as the port count.
   task automatic fifo_op_predict(input mprf_pkg::action_type act, input int pid,
                                  input logic [mprf_pkg::DATA_W-1:0] data,
                                  input logic [mprf_pkg::COUNT_W-1:0] want);
      int               cap;
      int               fill;
      int               n;
      logic [CNT_W-1:0] head;
      fifo_beat_type    b;
      cap  = 1 << ((size_cfg[pid] > DEPTH_LOG2) ? DEPTH_LOG2 : size_cfg[pid]);
      fill = (wr_cnt[pid] - rd_cnt[pid]) & CNT_MASK;
      n    = 0;
      head = rd_cnt[pid];
      b    = '0;
      b.port_id = mprf_pkg::PORT_W'(pid);
      b.tail    = 1'b1;
      case (act)
         mprf_pkg::ACT_WRITE: begin
            if (fill < cap) begin
               word_mem[pid][wr_cnt[pid] & (cap - 1)] = data;
               wr_cnt[pid] = wr_cnt[pid] + 1'b1;
               b.stored = 1'b1;
            end
         end
         mprf_pkg::ACT_READ: begin
            n = want;
            if (n > BURST_MAX) n = BURST_MAX;
            if (n > fill) n = fill;
            rd_cnt[pid] = rd_cnt[pid] + CNT_W'(n);
         end
         mprf_pkg::ACT_FLUSH: begin
            wr_cnt[pid] = '0;
            rd_cnt[pid] = '0;
         end
         default: ;
      endcase
      b.empty = (wr_cnt[pid] == rd_cnt[pid]);
      if (n == 0) begin
         rsp_beats_due.push_back(b);
      end else begin
         // words stream oldest first, all beats carry the post-read empty flag
         for (int i = 0; i < n; i++) begin
            b.word       = word_mem[pid][(head + i) & (cap - 1)];
            b.word_valid = 1'b1;
            b.grant      = mprf_pkg::COUNT_W'(n);
            b.tail       = (i == n - 1);
            rsp_beats_due.push_back(b);
         end
      end
   endtask

   // One request beat. start stays high across back-to-back ops; in this task it only
   // drops when a gap is taken, so it never gets two updates in one step.
   task automatic send_item(input mprf_pkg::action_type act, input int pid,
                            input logic [mprf_pkg::DATA_W-1:0] data,
                            input logic [mprf_pkg::COUNT_W-1:0] want);
      int gap;
      int roll;
      gap  = 0;
      roll = $urandom_range(0, 99);
      if (idle_gaps && roll >= 55)
         gap = (roll < 90) ? $urandom_range(1, 3) : $urandom_range(6, 25);
      if (gap > 0) begin
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      start         <= 1'b1;
      req_action    <= act;
      req_port_sel  <= mprf_pkg::PORT_W'(pid);
      req_wdata     <= data;
      req_req_count <= want;
      @(posedge clock);
      while (busy) @(posedge clock);
      fifo_op_predict(act, pid, data, want);
   endtask

   // Drop start and let every owed beat come out before touching registers.
   task automatic wait_idle(input int settle);
      start <= 1'b0;
      while (rsp_beats_due.size() != 0) @(posedge clock);
      repeat (settle) @(posedge clock);
   endtask

   // Size register write; the block clears that port's counters with it.
   task automatic set_port_size(input int pid, input logic [mprf_pkg::SIZE_W-1:0] size);
      csr_valid <= 1'b1;
      csr_index <= mprf_pkg::REG_IDX_W'(REG_SIZE_BASE + pid);
      csr_data  <= size;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid     <= 1'b0;
      size_cfg[pid] = size;
      wr_cnt[pid]   = '0;
      rd_cnt[pid]   = '0;
      @(posedge clock);
   endtask

   // Response checker: the receiver never stalls, so every strobe is a beat.
   always @(posedge clock) begin : rsp_check
      fifo_beat_type got;
      fifo_beat_type exp_beat;
      if (!reset && rsp_strobe === 1'b1) begin
         got = '{rsp_port_out, rsp_rdata, rsp_rdata_valid, rsp_write_taken,
                 rsp_granted, rsp_is_empty, rsp_last};
         if (rsp_beats_due.size() == 0) begin
            error_count++;
            if (error_count <= REPORT_MAX)
               $display("unexpected rsp beat at cycle %0d: port=%0d data=%h",
                        cycle_count, got.port_id, got.word);
         end else begin
            exp_beat = rsp_beats_due.pop_front();
            if (got !== exp_beat) begin
               error_count++;
               if (error_count <= REPORT_MAX) begin
                  $display("rsp mismatch at cycle %0d", cycle_count);
                  $display("  exp port=%0d data=%h dv=%b taken=%b grant=%0d empty=%b last=%b",
                           exp_beat.port_id, exp_beat.word, exp_beat.word_valid,
                           exp_beat.stored, exp_beat.grant, exp_beat.empty, exp_beat.tail);
                  $display("  got port=%0d data=%h dv=%b taken=%b grant=%0d empty=%b last=%b",
                           got.port_id, got.word, got.word_valid, got.stored, got.grant,
                           got.empty, got.tail);
               end
            end
         end
      end
   end

   initial begin : stimulus
      stim_row_type  row;
      fifo_beat_type typed_beat;
      int            pid;
      int            roll;
      int            burst;
      int            want;
      int            issued;
      foreach (size_cfg[p]) begin
         size_cfg[p] = mprf_pkg::SIZE_RESET;
         wr_cnt[p]   = '0;
         rd_cnt[p]   = '0;
      end
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // smallest ring on port 1, oversized size code on port 2
      set_port_size(1, 4'd0);
      set_port_size(2, 4'd15);

      // Directed ops. Typed rows check against the hand-written beat; the
      // model still runs so its state stays in step.
      foreach (directed_rows[i]) begin
         row = directed_rows[i];
         send_item(row.act, row.port_id, row.data, row.want);
         if (row.typed) begin
            typed_beat = '{row.port_id, '0, 1'b0, row.taken, '0, row.empty, 1'b1};
            void'(rsp_beats_due.pop_back());
            rsp_beats_due.push_back(typed_beat);
         end
      end

      // Random phases: new ring sizes, then mostly write bursts followed by
      // reads so that rings fill, wrap and drain; flushes and no-ops as noise.
      for (int phase = 0; phase < N_PHASES; phase++) begin
         wait_idle(CSR_SETTLE);
         idle_gaps = (phase % 3 != 1);   // every third phase runs without gaps
         for (int p = 0; p < N_PORTS; p++) begin
            if (phase < 3)
               set_port_size(p, PHASE_SIZES[phase][p]);
            else if ($urandom_range(0, 1) == 1)
               set_port_size(p, mprf_pkg::SIZE_W'($urandom_range(0, 15)));
         end
         issued = 0;
         while (issued < PHASE_ITEMS) begin
            pid  = $urandom_range(0, N_PORTS - 1);
            roll = $urandom_range(0, 99);
            if (roll < 45) begin
               // long bursts overfill the small rings and push big ones past a burst
               burst = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 45)
                                                   : $urandom_range(1, 8);
               repeat (burst) send_item(mprf_pkg::ACT_WRITE, pid,
                                        mprf_pkg::DATA_W'($urandom),
                                        mprf_pkg::COUNT_W'($urandom));
               issued += burst;
            end else begin
               if (roll < 85) begin
                  roll = $urandom_range(0, 9);
                  want = (roll < 7) ? $urandom_range(0, 12) :
                         (roll < 9) ? $urandom_range(13, 40) : $urandom_range(41, 63);
                  send_item(mprf_pkg::ACT_READ, pid, mprf_pkg::DATA_W'($urandom),
                            mprf_pkg::COUNT_W'(want));
               end else if (roll < 93) begin
                  send_item(mprf_pkg::ACT_FLUSH, pid, mprf_pkg::DATA_W'($urandom),
                            mprf_pkg::COUNT_W'($urandom));
               end else begin
                  send_item(mprf_pkg::ACT_NOP, pid, mprf_pkg::DATA_W'($urandom),
                            mprf_pkg::COUNT_W'($urandom));
               end
               issued++;
            end
         end
      end

      wait_idle(END_SETTLE);
      error_count += rsp_beats_due.size();
      if (error_count == 0)
         $display("simulation ok");
      else
         $display("simulation failed");
      $finish;
   end

endmodule
